@@ hdl/cbor_head_decoder_top_macros.svh @@
// Assertion macros shared by the CBOR head decoder RTL.
`ifndef CBOR_HEAD_DECODER_TOP_MACROS_SVH
`define CBOR_HEAD_DECODER_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CBD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define CBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/cbd_pkg.sv @@
// Types, codes and constants of the CBOR head decoder.
package cbd_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 32;

    localparam int PADDR_W = 3;

    localparam logic REG_ELEM_BUDGET  = 1'b0;
    localparam logic REG_RESULT_BYTES = 1'b1;

    localparam logic [31:0] ELEM_BUDGET_RESET  = 32'hFFFF_FFFF;
    localparam logic [3:0]  RESULT_BYTES_RESET = 4'd4;

    localparam logic [4:0]  INFO_MASK         = 5'h1F;
    localparam logic [4:0]  INFO_DIRECT_MAX   = 5'd23;
    localparam logic [4:0]  INFO_ARG_LAST     = 5'd27;
    localparam logic [2:0]  MAJOR_MASK        = 3'h7;
    localparam logic [63:0] PRIM_MAX          = 64'hFF;
    localparam logic [63:0] INT_LIMIT         = 64'h8000_0000;

    localparam logic [2:0] MAJOR_NEG_INT = 3'd1;
    localparam logic [2:0] MAJOR_BYTES   = 3'd2;
    localparam logic [2:0] MAJOR_TEXT    = 3'd3;
    localparam logic [2:0] MAJOR_LIST    = 3'd4;
    localparam logic [2:0] MAJOR_MAP     = 3'd5;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_BUDGET   = 3'd1;
    localparam logic [2:0] ERR_WIDE     = 3'd2;
    localparam logic [2:0] ERR_TRUNC    = 3'd3;
    localparam logic [2:0] ERR_STRING   = 3'd4;
    localparam logic [2:0] ERR_RESERVED = 3'd5;

    typedef enum logic [3:0] {
        PH_HEAD = 4'b0001,
        PH_ARG  = 4'b0010,
        PH_SKIP = 4'b0100,
        PH_ERR  = 4'b1000
    } cbd_phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_payload;
    } cbd_in_t;

    typedef struct packed {
        logic [2:0]         head_major;
        logic [63:0]        argument;
        logic signed [31:0] signed_value;
        logic               int_fits;
        logic               prim_fits;
        logic [32:0]        item_count;
        logic [2:0]         error_code;
    } cbd_out_t;

    typedef struct packed {
        cbd_phase_t  phase;
        logic [2:0]  held_major;
        logic [63:0] arg_shift;
        logic [3:0]  arg_bytes_left;
        logic [31:0] budget_left;
    } cbd_state_t;

    typedef struct packed {
        logic [31:0] elem_budget;
        logic [3:0]  result_bytes;
        logic        budget_load;
        logic [31:0] budget_value;
    } cbd_cfg_t;

endpackage

@@ hdl/cbd_regs.sv @@
// APB configuration registers of the CBOR head decoder.
module cbd_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cbd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output cbd_pkg::cbd_cfg_t           cfg
);
    import cbd_pkg::*;

    logic [31:0] elem_budget_reg;
    logic [3:0]  result_bytes_reg;
    logic        wr_en;
    logic        reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_budget_reg  <= ELEM_BUDGET_RESET;
            result_bytes_reg <= RESULT_BYTES_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_ELEM_BUDGET:  elem_budget_reg  <= pwdata;
                REG_RESULT_BYTES: result_bytes_reg <= pwdata[3:0];
                default:          elem_budget_reg  <= elem_budget_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_ELEM_BUDGET:  prdata = elem_budget_reg;
            REG_RESULT_BYTES: prdata = {28'd0, result_bytes_reg};
            default:          prdata = 32'd0;
        endcase
    end

    assign cfg.elem_budget  = elem_budget_reg;
    assign cfg.result_bytes = result_bytes_reg;
    assign cfg.budget_load  = wr_en && (reg_sel == REG_ELEM_BUDGET);
    assign cfg.budget_value = pwdata;

endmodule

@@ hdl/cbd_step.sv @@
// Per-byte next-state and result logic of the CBOR head decoder.
module cbd_step #(
    parameter int COUNT_WIDTH = cbd_pkg::COUNT_WIDTH_DEFAULT
) (
    input  cbd_pkg::cbd_in_t     in_item,
    input  cbd_pkg::cbd_state_t  st,
    input  logic [COUNT_WIDTH-1:0] string_left,
    input  cbd_pkg::cbd_cfg_t    cfg,
    output cbd_pkg::cbd_state_t  st_next,
    output logic [COUNT_WIDTH-1:0] string_left_next,
    output logic                 emit,
    output cbd_pkg::cbd_out_t    result
);
    import cbd_pkg::*;

    logic                   eop;
    logic [4:0]             info;
    logic [3:0]             len;
    logic [63:0]            shifted;
    logic [3:0]             abl_dec;
    logic [COUNT_WIDTH-1:0] sl_dec;
    logic                   do_finish;
    logic [63:0]            fin_arg;
    logic [2:0]             fin_major;
    logic                   err;
    logic [2:0]             err_code;
    logic                   counted;
    logic                   is_string;
    logic                   fits;

    assign eop     = in_item.end_of_payload;
    assign info    = in_item.data_byte[4:0] & INFO_MASK;
    assign len     = 4'd1 << info[1:0];
    assign shifted = {st.arg_shift[55:0], in_item.data_byte};
    assign abl_dec = st.arg_bytes_left - 4'd1;
    assign sl_dec  = string_left - COUNT_WIDTH'(1);

    always_comb
    begin
        st_next          = st;
        string_left_next = string_left;
        emit             = 1'b0;
        result           = '0;
        do_finish        = 1'b0;
        fin_arg          = 64'd0;
        fin_major        = st.held_major;
        err              = 1'b0;
        err_code         = ERR_NONE;
        counted          = 1'b0;
        is_string        = 1'b0;
        fits             = 1'b0;

        case (st.phase)
            PH_ERR:
            begin
                if (eop)
                begin
                    st_next.phase       = PH_HEAD;
                    st_next.budget_left = cfg.elem_budget;
                end
            end
            PH_SKIP:
            begin
                string_left_next = sl_dec;
                if (sl_dec == '0)
                begin
                    st_next.phase = PH_HEAD;
                    if (eop)
                    begin
                        st_next.budget_left = cfg.elem_budget;
                    end
                end
                else if (eop)
                begin
                    err      = 1'b1;
                    err_code = ERR_STRING;
                end
            end
            PH_ARG:
            begin
                st_next.arg_shift      = shifted;
                st_next.arg_bytes_left = abl_dec;
                if (abl_dec == 4'd0)
                begin
                    do_finish = 1'b1;
                    fin_arg   = shifted;
                end
                else if (eop)
                begin
                    err      = 1'b1;
                    err_code = ERR_TRUNC;
                end
            end
            PH_HEAD:
            begin
                if (st.budget_left == 32'd0)
                begin
                    err      = 1'b1;
                    err_code = ERR_BUDGET;
                end
                else
                begin
                    fin_major          = in_item.data_byte[7:5] & MAJOR_MASK;
                    st_next.held_major = fin_major;
                    if (info > INFO_ARG_LAST)
                    begin
                        err      = 1'b1;
                        err_code = ERR_RESERVED;
                    end
                    else if (info <= INFO_DIRECT_MAX)
                    begin
                        do_finish = 1'b1;
                        fin_arg   = {59'd0, info};
                    end
                    else if (len > cfg.result_bytes)
                    begin
                        err      = 1'b1;
                        err_code = ERR_WIDE;
                    end
                    else if (eop)
                    begin
                        err      = 1'b1;
                        err_code = ERR_TRUNC;
                    end
                    else
                    begin
                        st_next.arg_shift      = 64'd0;
                        st_next.arg_bytes_left = len;
                        st_next.phase          = PH_ARG;
                    end
                end
            end
            default:
            begin
                st_next.phase = PH_HEAD;
            end
        endcase

        // Complete a head: range checks, result fields, then the next phase.
        counted   = (fin_major >= MAJOR_BYTES) && (fin_major <= MAJOR_MAP);
        is_string = (fin_major == MAJOR_BYTES) || (fin_major == MAJOR_TEXT);
        fits      = fin_arg < INT_LIMIT;
        if (do_finish)
        begin
            if (counted && ((fin_arg >> COUNT_WIDTH) != 64'd0))
            begin
                err      = 1'b1;
                err_code = ERR_WIDE;
            end
            else if (is_string && (fin_arg != 64'd0) && eop)
            begin
                err      = 1'b1;
                err_code = ERR_STRING;
            end
            else
            begin
                emit                = 1'b1;
                st_next.budget_left = st.budget_left - 32'd1;
                result.head_major   = fin_major;
                result.argument     = fin_arg;
                if (fits)
                begin
                    result.signed_value = (fin_major == MAJOR_NEG_INT) ? ~fin_arg[31:0]
                                                                       : fin_arg[31:0];
                end
                result.int_fits   = fits;
                result.prim_fits  = fin_arg <= PRIM_MAX;
                result.error_code = ERR_NONE;
                if (fin_major == MAJOR_LIST)
                begin
                    result.item_count = fin_arg[32:0];
                end
                else if (fin_major == MAJOR_MAP)
                begin
                    result.item_count = {fin_arg[31:0], 1'b0};
                end
                if (is_string && (fin_arg != 64'd0))
                begin
                    string_left_next = fin_arg[COUNT_WIDTH-1:0];
                    st_next.phase    = PH_SKIP;
                end
                else
                begin
                    st_next.phase = PH_HEAD;
                    if (eop)
                    begin
                        st_next.budget_left = cfg.elem_budget;
                    end
                end
            end
        end

        // An error gives one all-zero result with its code and is sticky until the end of the payload.
        if (err)
        begin
            emit              = 1'b1;
            result            = '0;
            result.error_code = err_code;
            if (eop)
            begin
                st_next.phase       = PH_HEAD;
                st_next.budget_left = cfg.elem_budget;
            end
            else
            begin
                st_next.phase = PH_ERR;
            end
        end
    end

endmodule

@@ hdl/cbor_head_decoder_top.sv @@
// Top level of the CBOR data item head decoder.
// A head's last byte enters the input register; its result then enters the result register.
// Throughput: one payload byte per cycle, except while a new result waits on a stalled full
// result register; the step logic between the input and result registers handles any byte combinationally.
// Bytes that complete no head and raise no error (argument, string and post-error bytes) give no result.
// Reset (rst_n low, asynchronous) empties both registers, returns to the head phase
// and reloads the element budget from its reset value.
`include "cbor_head_decoder_top_macros.svh"

module cbor_head_decoder_top #(
    parameter int COUNT_WIDTH = cbd_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  cbd_pkg::cbd_in_t            in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output cbd_pkg::cbd_out_t           out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cbd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import cbd_pkg::*;

    cbd_cfg_t               cfg;

    // Input register: holds the byte the step logic works on.
    logic                   in_valid_reg;
    cbd_in_t                in_item_reg;

    // Decoder state, advanced once per byte leaving the input register.
    cbd_state_t             st_reg;
    cbd_state_t             st_next;
    logic [COUNT_WIDTH-1:0] string_left_reg;
    logic [COUNT_WIDTH-1:0] string_left_next;

    // Result register toward the consumer.
    logic                   out_valid_reg;
    cbd_out_t               out_data_reg;

    logic                   step_emit;
    cbd_out_t               step_result;
    logic                   out_free;
    logic                   advance;
    logic                   in_xfer;

    cbd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cbd_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .in_item          (in_item_reg),
        .st               (st_reg),
        .string_left      (string_left_reg),
        .cfg              (cfg),
        .st_next          (st_next),
        .string_left_next (string_left_next),
        .emit             (step_emit),
        .result           (step_result)
    );

    // Advance the held byte when it makes no result, or when the result slot
    // is empty or being drained this cycle.
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && (!step_emit || out_free);
    assign in_stall = in_valid_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_item_reg <= in_data;
        end
    end

    // State update; a budget register write reloads the remaining count and wins over the byte
    // step (the user must write only while the decoder is idle; the block does not enforce it).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.phase          <= PH_HEAD;
            st_reg.held_major     <= 3'd0;
            st_reg.arg_shift      <= 64'd0;
            st_reg.arg_bytes_left <= 4'd0;
            st_reg.budget_left    <= ELEM_BUDGET_RESET;
            string_left_reg       <= '0;
        end
        else if (cfg.budget_load)
        begin
            st_reg.budget_left <= cfg.budget_value;
        end
        else if (advance)
        begin
            st_reg          <= st_next;
            string_left_reg <= string_left_next;
        end
    end

    // Load a new result when an advancing byte emits one; drop the old one once transferred out.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && step_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && step_emit)
        begin
            out_data_reg <= step_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `CBD_ASSERT(a_stall_needs_item, !in_stall || in_valid_reg, "stall with empty input register")
    `CBD_ASSERT_NEXT(a_emit_loads_out, advance && step_emit, out_valid_reg, "result was lost")
    `CBD_ASSERT(a_err_zero, !(out_valid_reg && (out_data_reg.error_code != ERR_NONE)) || ((out_data_reg.argument == 64'd0) && (out_data_reg.item_count == 33'd0)), "error result carries data")
    `CBD_ASSERT(a_arg_left, (st_reg.phase != PH_ARG) || (st_reg.arg_bytes_left != 4'd0), "argument phase with no bytes left")
    `CBD_ASSERT(a_skip_left, (st_reg.phase != PH_SKIP) || (string_left_reg != '0), "skip phase with empty string")

endmodule

@@ verif/cbor_head_checker.sv @@
// Head decoder predictor and result scoreboard, watching both channels and the register port.
`timescale 1ns / 1ps

module cbor_head_checker
    import cbd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  cbd_in_t             in_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  cbd_out_t            out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output int                  mismatches,
    output int                  pending
);

    // Register copies
    logic [31:0] elem_budget;
    logic [3:0]  result_bytes;

    // Decoder state
    cbd_phase_t  phase;
    logic [2:0]  held_major;
    logic [63:0] arg_shift;
    logic [3:0]  arg_bytes_left;
    logic [63:0] string_left;
    logic [31:0] budget_left;

    cbd_out_t expected_heads[$];
    int       mismatch_count = 0;

    assign mismatches = mismatch_count;

    function automatic void close_payload();
        phase = PH_HEAD;
        budget_left = elem_budget;
    endfunction

    function automatic bit raise_error(input logic [2:0] code, input logic eop,
                                       output cbd_out_t head);
        head = '0;
        head.error_code = code;
        if (eop)
            close_payload();
        else
            phase = PH_ERR;
        return 1'b1;
    endfunction

    function automatic bit complete_head(input logic [63:0] arg, input logic eop,
                                         output cbd_out_t head);
        logic counted;
        logic is_string;
        counted = (held_major >= MAJOR_BYTES) && (held_major <= MAJOR_MAP);
        is_string = (held_major == MAJOR_BYTES) || (held_major == MAJOR_TEXT);
        // String lengths and child counts must fit the count width
        if (counted && ((arg >> (COUNT_WIDTH - 1)) >> 1) != 64'h0)
            return raise_error(ERR_WIDE, eop, head);
        if (is_string && arg != 64'h0 && eop)
            return raise_error(ERR_STRING, eop, head);
        budget_left = budget_left - 32'h1;
        head = '0;
        head.head_major = held_major;
        head.argument = arg;
        head.int_fits = (arg < INT_LIMIT);
        head.prim_fits = (arg <= PRIM_MAX);
        if (head.int_fits)
            head.signed_value = (held_major == MAJOR_NEG_INT) ? ~arg[31:0] : arg[31:0];
        if (held_major == MAJOR_LIST)
            head.item_count = arg[32:0];
        else if (held_major == MAJOR_MAP)
            head.item_count = {arg[31:0], 1'b0};
        head.error_code = ERR_NONE;
        if (is_string && arg != 64'h0)
        begin
            string_left = arg;
            phase = PH_SKIP;
        end
        else if (eop)
            close_payload();
        else
            phase = PH_HEAD;
        return 1'b1;
    endfunction

    // Advance the decoder by one payload byte; return 1 when a result is due.
    function automatic bit decode_byte(input cbd_in_t item, output cbd_out_t head);
        logic [4:0] info;
        logic [3:0] arg_len;
        head = '0;
        if (phase == PH_ERR)
        begin
            if (item.end_of_payload)
                close_payload();
            return 1'b0;
        end
        if (phase == PH_SKIP)
        begin
            string_left = string_left - 64'h1;
            if (string_left == 64'h0)
            begin
                if (item.end_of_payload)
                    close_payload();
                else
                    phase = PH_HEAD;
                return 1'b0;
            end
            if (item.end_of_payload)
                return raise_error(ERR_STRING, 1'b1, head);
            return 1'b0;
        end
        if (phase == PH_ARG)
        begin
            arg_shift = {arg_shift[55:0], item.data_byte};
            arg_bytes_left = arg_bytes_left - 4'h1;
            if (arg_bytes_left == 4'h0)
                return complete_head(arg_shift, item.end_of_payload, head);
            if (item.end_of_payload)
                return raise_error(ERR_TRUNC, 1'b1, head);
            return 1'b0;
        end
        // Head byte
        if (budget_left == 32'h0)
            return raise_error(ERR_BUDGET, item.end_of_payload, head);
        info = item.data_byte[4:0] & INFO_MASK;
        held_major = item.data_byte[7:5] & MAJOR_MASK;
        if (info > INFO_ARG_LAST)
            return raise_error(ERR_RESERVED, item.end_of_payload, head);
        if (info <= INFO_DIRECT_MAX)
            return complete_head({59'h0, info}, item.end_of_payload, head);
        arg_len = 4'h1 << (info - INFO_DIRECT_MAX - 5'd1);
        if (arg_len > result_bytes)
            return raise_error(ERR_WIDE, item.end_of_payload, head);
        if (item.end_of_payload)
            return raise_error(ERR_TRUNC, 1'b1, head);
        arg_shift = 64'h0;
        arg_bytes_left = arg_len;
        phase = PH_ARG;
        return 1'b0;
    endfunction

    task automatic check_field(input string field_name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h",
                     $time, field_name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        cbd_out_t want;
        cbd_out_t predicted;
        if (!rst_n)
        begin
            elem_budget = ELEM_BUDGET_RESET;
            result_bytes = RESULT_BYTES_RESET;
            phase = PH_HEAD;
            held_major = 3'h0;
            arg_shift = 64'h0;
            arg_bytes_left = 4'h0;
            string_left = 64'h0;
            budget_left = ELEM_BUDGET_RESET;
            expected_heads.delete();
            pending <= 0;
        end
        else
        begin
            // Compare the output transfer before adding this edge's prediction
            if (out_valid && !out_stall)
            begin
                if (expected_heads.size() == 0)
                begin
                    $display("%0t ns: result with nothing expected, actual %h", $time, out_data);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_heads.pop_front();
                    check_field("head_major", 64'(want.head_major),
                                64'(out_data.head_major));
                    check_field("argument", want.argument, out_data.argument);
                    check_field("signed_value", 64'(want.signed_value),
                                64'(out_data.signed_value));
                    check_field("int_fits", 64'(want.int_fits), 64'(out_data.int_fits));
                    check_field("prim_fits", 64'(want.prim_fits), 64'(out_data.prim_fits));
                    check_field("item_count", 64'(want.item_count),
                                64'(out_data.item_count));
                    check_field("error_code", 64'(want.error_code),
                                64'(out_data.error_code));
                end
            end
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00)
            begin
                if (paddr[PADDR_W-1:2] == REG_ELEM_BUDGET)
                begin
                    elem_budget = pwdata;
                    budget_left = pwdata;
                end
                else if (paddr[PADDR_W-1:2] == REG_RESULT_BYTES)
                    result_bytes = pwdata[3:0];
            end
            if (in_valid && !in_stall)
            begin
                if (decode_byte(in_data, predicted))
                    expected_heads.push_back(predicted);
            end
            pending <= expected_heads.size();
        end
    end

endmodule

@@ verif/cbor_head_decoder_top_tb.sv @@
// Stimulus, clock, reset and verdict for the CBOR head decoder testbench.
`timescale 1ns / 1ps

module cbor_head_decoder_top_tb;
    import cbd_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 4;
    // Result passes the input and result registers after its last byte; leave margin for bytes with no result
    localparam int SETTLE_CYCLES = 4;
    // Long receiver hold-off, well past the block's two register stages
    localparam int HOLD_CYCLES   = 80;
    // ~1550 bytes, each at worst a full sender gap plus a full receiver stall, plus
    // the hold-off and drains; the limit allows several times that worst case
    localparam int CYCLE_LIMIT   = 400000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    cbd_in_t             in_data;
    logic                out_valid;
    logic                out_stall;
    cbd_out_t            out_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    int mismatches;
    int results_pending;

    // Idling knobs, in percent per transfer or per cycle
    int gap_pct  = 0;
    int stall_pct = 0;
    bit gap_on   = 1'b1;
    // The stimulus bumps hold_requests; the receiver counts holds_done
    int hold_requests = 0;
    int holds_done    = 0;

    int bytes_sent  = 0;
    int cycle_count = 0;

    logic [7:0] frame_bytes[$];

    cbor_head_decoder_top #(
        .COUNT_WIDTH(COUNT_WIDTH_DEFAULT)
    ) uut (.*);

    cbor_head_checker #(
        .COUNT_WIDTH(COUNT_WIDTH_DEFAULT)
    ) checker_i (
        .*,
        .mismatches(mismatches),
        .pending(results_pending)
    );

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    // Watchdog: end the run if the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("cbor_head_decoder_top verification failed");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus the long hold-off on request.
    // Each path drives out_stall once per edge.
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_done < hold_requests)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                holds_done++;
            end
            else if (stall_pct != 0 && $urandom_range(99) < stall_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(17, 1)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Offer one byte and hold it until the transfer happens. An optional
    // random gap with valid low goes in front; valid stays high between
    // back-to-back bytes so it is never dropped and raised in one step.
    task automatic send_byte(input logic [7:0] data, input logic eop);
        int gap;
        if (gap_on && gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            gap = $urandom_range(17, 1);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data <= '{data_byte: data, end_of_payload: eop};
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
    endtask

    // Send the first count bytes of the frame, end_of_payload on the last one
    task automatic send_frame(input int count);
        for (int i = 0; i < count; i++)
            send_byte(frame_bytes[i], i == count - 1);
    endtask

    // Random bytes with random payload ends
    task automatic send_noise();
        repeat ($urandom_range(8, 1))
            send_byte(8'($urandom_range(255)), $urandom_range(5) == 0);
    endtask

    // Drop valid, wait for every expected result, then let the pipe settle
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (results_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the write lands when pready is seen high
    task automatic write_register(input logic [PADDR_W-3:0] reg_index,
                                  input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {reg_index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Argument of the width that the additional info announces, biased
    // toward the edges: all ones, zero, the sign boundary, the count-width edge
    function automatic logic [63:0] pick_argument(input logic [4:0] info);
        logic [63:0] mask;
        logic [63:0] raw;
        int          arg_len;
        arg_len = 1 << (info - INFO_DIRECT_MAX - 5'd1);
        mask = (arg_len == 8) ? '1 : ((64'h1 << (8 * arg_len)) - 64'h1);
        raw = {$urandom, $urandom};
        case ($urandom_range(7))
            0: return mask;
            1: return 64'h0;
            2: return (mask >> 1) + 64'h1;
            3: return mask >> 1;
            4: return raw & mask & 64'hFFFF_FFFF;
            5: return {31'h0, 1'b1, raw[31:0]} & mask;
            default: return raw & mask;
        endcase
    endfunction

    // Append a head byte and its big-endian argument bytes
    function automatic void append_head(input logic [2:0] major, input logic [4:0] info,
                                        input logic [63:0] arg);
        int arg_len;
        frame_bytes.push_back({major, info});
        if (info > INFO_DIRECT_MAX && info <= INFO_ARG_LAST)
        begin
            arg_len = 1 << (info - INFO_DIRECT_MAX - 5'd1);
            for (int i = arg_len - 1; i >= 0; i--)
                frame_bytes.push_back(arg[8*i +: 8]);
        end
    endfunction

    // Build a mostly well-formed payload of a few heads with random content.
    // Strings stay short so their content really gets skipped; a rare
    // huge length runs off the end of the payload on purpose.
    function automatic void build_payload(input int heads);
        logic [2:0]  major;
        logic [4:0]  info;
        logic [63:0] arg;
        int          content;
        int          pick;
        frame_bytes.delete();
        repeat (heads)
        begin
            major = 3'($urandom_range(7));
            pick = $urandom_range(99);
            if (major == MAJOR_BYTES || major == MAJOR_TEXT)
            begin
                if (pick < 60)
                begin
                    info = 5'($urandom_range(5));
                    arg = 64'(info);
                end
                else if (pick < 80)
                begin
                    info = INFO_DIRECT_MAX + 5'd1;
                    arg = 64'($urandom_range(12));
                end
                else if (pick < 92)
                begin
                    info = 5'($urandom_range(INFO_ARG_LAST, INFO_DIRECT_MAX + 2));
                    arg = 64'($urandom_range(6));
                end
                else
                begin
                    info = 5'($urandom_range(INFO_ARG_LAST, INFO_DIRECT_MAX + 1));
                    arg = pick_argument(info);
                end
                append_head(major, info, arg);
                content = (arg > 64'd12) ? $urandom_range(3) : int'(arg);
                repeat (content) frame_bytes.push_back(8'($urandom_range(255)));
            end
            else
            begin
                if (pick < 45)
                    info = 5'($urandom_range(INFO_DIRECT_MAX));
                else if (pick < 96)
                    info = 5'($urandom_range(INFO_ARG_LAST, INFO_DIRECT_MAX + 1));
                else
                    info = 5'($urandom_range(31, INFO_ARG_LAST + 1));
                arg = (info <= INFO_DIRECT_MAX) ? 64'(info) : pick_argument(info);
                append_head(major, info, arg);
            end
        end
    endfunction

    // Mostly whole payloads, some cut short, the rest noise. Some payloads
    // run with no sender gaps at all.
    task automatic send_random(input int count);
        int stop_at;
        int pick;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at)
        begin
            pick = $urandom_range(99);
            gap_on = ($urandom_range(4) != 0);
            build_payload($urandom_range(6, 1));
            if (pick < 75)
                send_frame(frame_bytes.size());
            else if (pick < 90)
                send_frame($urandom_range(frame_bytes.size(), 1));
            else
                send_noise();
        end
        gap_on = 1'b1;
    endtask

    initial
    begin
        // Drive every input to a known value before the first edge
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, reset settings: unlimited budget, 4-byte arguments
        gap_pct = 20;
        stall_pct = 20;
        // Zero, negative int past 2^31, map with count doubling, skipped byte
        // string, list; then a too-wide 8-byte head whose error swallows the
        // rest of the payload
        frame_bytes = '{8'h00, 8'h3A, 8'h80, 8'h00, 8'h00, 8'h00, 8'hB8, 8'hFF,
                        8'h42, 8'h11, 8'h22, 8'h85, 8'h1B, 8'h00, 8'h00};
        send_frame(frame_bytes.size());
        // Reserved info on the end-of-payload byte itself
        frame_bytes = '{8'hFF};
        send_frame(frame_bytes.size());
        // Argument cut off by the end of the payload
        frame_bytes = '{8'h19, 8'h01};
        send_frame(frame_bytes.size());
        // String overrun on the head byte, then inside the string content
        frame_bytes = '{8'h63};
        send_frame(frame_bytes.size());
        frame_bytes = '{8'h62, 8'h41};
        send_frame(frame_bytes.size());
        // Tag with a one-byte argument, then a simple value closing the payload
        frame_bytes = '{8'hD8, 8'h2A, 8'hF4};
        send_frame(frame_bytes.size());
        wait_for_results();

        // Budget of one head: the second head runs out, the third is swallowed
        write_register(REG_ELEM_BUDGET, 32'd1);
        write_register(REG_RESULT_BYTES, 32'd8);
        frame_bytes = '{8'h01, 8'h02, 8'h03};
        send_frame(frame_bytes.size());
        wait_for_results();

        // Widest arguments, unlimited budget, idling on both sides
        write_register(REG_ELEM_BUDGET, 32'hFFFF_FFFF);
        gap_pct = 30;
        stall_pct = 30;
        send_random(400);
        wait_for_results();

        // Tight budget, narrow arguments; hold the receiver off while the
        // sender keeps offering so the block backs up and stalls its input
        write_register(REG_ELEM_BUDGET, 32'd3);
        write_register(REG_RESULT_BYTES, 32'd4);
        gap_pct = 10;
        stall_pct = 15;
        hold_requests++;
        send_random(300);
        wait_for_results();

        // No budget at all: every head is refused
        write_register(REG_ELEM_BUDGET, 32'd0);
        write_register(REG_RESULT_BYTES, 32'd6);
        gap_pct = 25;
        stall_pct = 25;
        send_random(100);
        wait_for_results();

        // Mid-size budget; pause the sender halfway until every result is in
        write_register(REG_ELEM_BUDGET, 32'd20);
        write_register(REG_RESULT_BYTES, 32'd8);
        gap_pct = 15;
        stall_pct = 40;
        send_random(200);
        wait_for_results();
        send_random(200);
        wait_for_results();

        // Last stretch at full rate, no idling on either side
        write_register(REG_ELEM_BUDGET, 32'hFFFF_FFFF);
        write_register(REG_RESULT_BYTES, 32'd5);
        gap_pct = 0;
        stall_pct = 0;
        send_random(300);
        wait_for_results();

        if (mismatches == 0 && results_pending == 0)
            $display("cbor_head_decoder_top verification clean");
        else
            $display("cbor_head_decoder_top verification failed");
        $finish;
    end

endmodule
